/* hdl/nfcs_pkg.sv */
// Shared types and constants of the NAND flash command sequencer.
package nfcs_pkg;

    localparam int ROW_W   = 24;
    localparam int BLOCK_W = 18;

    // Request and data item codes.
    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_PROG  = 3'd1;
    localparam logic [2:0] OP_ERASE = 3'd2;
    localparam logic [2:0] OP_ID    = 3'd3;
    localparam logic [2:0] OP_RESET = 3'd4;
    localparam logic [2:0] OP_HOST  = 3'd5;
    localparam logic [2:0] OP_BUS   = 3'd6;
    localparam logic [2:0] OP_TICK  = 3'd7;

    // Bus cycle kinds.
    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_CMD  = 3'd1;
    localparam logic [2:0] K_ADDR = 3'd2;
    localparam logic [2:0] K_WR   = 3'd3;
    localparam logic [2:0] K_RD   = 3'd4;

    // Status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FAIL    = 3'd1;
    localparam logic [2:0] ST_TIMEOUT = 3'd2;
    localparam logic [2:0] ST_ID_SAME = 3'd3;
    localparam logic [2:0] ST_UNEXP   = 3'd4;

    // Flash commands.
    localparam logic [7:0] CMD_READ0  = 8'h00;
    localparam logic [7:0] CMD_READ1  = 8'h30;
    localparam logic [7:0] CMD_PROG0  = 8'h80;
    localparam logic [7:0] CMD_PROG1  = 8'h10;
    localparam logic [7:0] CMD_ERASE0 = 8'h60;
    localparam logic [7:0] CMD_ERASE1 = 8'hD0;
    localparam logic [7:0] CMD_STATUS = 8'h70;
    localparam logic [7:0] CMD_RESET  = 8'hFF;
    localparam logic [7:0] CMD_READID = 8'h90;
    localparam logic [7:0] COL_ADDR   = 8'h00;
    localparam logic [7:0] ID_ADDR    = 8'h00;

    localparam int          ID_BYTES      = 5;
    localparam logic [31:0] TIMEOUT_RESET = 32'd3000000;

    // Job types handed from the front to the back.
    localparam logic [2:0] J_SINGLE = 3'd0;
    localparam logic [2:0] J_READ   = 3'd1;
    localparam logic [2:0] J_PROG   = 3'd2;
    localparam logic [2:0] J_ERASE  = 3'd3;
    localparam logic [2:0] J_ID     = 3'd4;
    localparam logic [2:0] J_RESET  = 3'd5;
    localparam logic [2:0] J_WRLAST = 3'd6;
    localparam logic [2:0] J_STATUS = 3'd7;

    typedef struct packed {
        logic [2:0]       jtype;
        logic [ROW_W-1:0] row;
        logic [2:0]       kind;
        logic [7:0]       bus;
        logic             hv;
        logic [7:0]       hd;
        logic             done;
        logic [2:0]       st;
    } job_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] bus;
        logic       hv;
        logic [7:0] hd;
        logic       done;
        logic [2:0] st;
        logic       last;
    } res_t;

endpackage

/* hdl/nfcs_front.sv */
// Front part: accepts items, tracks the request phase and emits at most one job per item.
module nfcs_front #(
    parameter int PAGE_BYTES      = 2112,
    parameter int PAGES_PER_BLOCK = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic [2:0]                      op,
    input  logic [nfcs_pkg::ROW_W-1:0]      page_number,
    input  logic [nfcs_pkg::BLOCK_W-1:0]    block_number,
    input  logic [7:0]                      host_byte,
    input  logic [7:0]                      bus_byte,
    input  logic                            ready_req,
    input  logic [31:0]                     timeout_ticks,
    input  logic                            job_full,
    output logic                            job_push,
    output nfcs_pkg::job_t                  job
);
    import nfcs_pkg::*;

    localparam int CNT_W = $clog2(PAGE_BYTES + 1);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_WAIT = 3'd1;
    localparam logic [2:0] PH_READ = 3'd2;
    localparam logic [2:0] PH_PROG = 3'd3;
    localparam logic [2:0] PH_STAT = 3'd4;
    localparam logic [2:0] PH_ID   = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic [2:0]       kind_reg, kind_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      wait_reg, wait_next;
    logic [7:0]       first_reg, first_next;
    logic             same_reg, same_next;

    logic             accept;
    logic [CNT_W-1:0] count_inc;
    logic [31:0]      wait_inc;
    logic [ROW_W-1:0] erase_row;
    logic             same_now;

    function automatic job_t mk_single(logic [2:0] kind, logic [7:0] bus, logic hv,
                                       logic [7:0] hd, logic done, logic [2:0] st);
        job_t j;
        j       = '0;
        j.jtype = J_SINGLE;
        j.kind  = kind;
        j.bus   = bus;
        j.hv    = hv;
        j.hd    = hd;
        j.done  = done;
        j.st    = st;
        return j;
    endfunction

    function automatic job_t mk_seq(logic [2:0] jtype, logic [ROW_W-1:0] row,
                                    logic [7:0] bus);
        job_t j;
        j       = '0;
        j.jtype = jtype;
        j.row   = row;
        j.bus   = bus;
        return j;
    endfunction

    assign accept    = push & ~job_full;
    assign count_inc = count_reg + CNT_W'(1);
    assign wait_inc  = (wait_reg == '1) ? wait_reg : wait_reg + 32'd1;
    // Only the low row bits are sent, so the product is kept modulo the row width.
    assign erase_row = ROW_W'(block_number) * ROW_W'(PAGES_PER_BLOCK);
    assign same_now  = same_reg & ((count_reg == '0) | (bus_byte == first_reg));

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        count_next = count_reg;
        wait_next  = wait_reg;
        first_next = first_reg;
        same_next  = same_reg;
        job_push   = 1'b0;
        job        = '0;
        if (accept)
        begin
            unique case (op)
                OP_READ, OP_PROG, OP_ERASE, OP_ID, OP_RESET:
                begin
                    job_push = 1'b1;
                    if (phase_reg != PH_IDLE)
                    begin
                        job = mk_single(K_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ST_UNEXP);
                    end
                    else
                    begin
                        kind_next  = op;
                        wait_next  = '0;
                        count_next = '0;
                        unique case (op)
                            OP_READ:
                            begin
                                job        = mk_seq(J_READ, page_number, 8'h00);
                                phase_next = PH_WAIT;
                            end
                            OP_PROG:
                            begin
                                job        = mk_seq(J_PROG, page_number, 8'h00);
                                phase_next = PH_PROG;
                            end
                            OP_ERASE:
                            begin
                                job        = mk_seq(J_ERASE, erase_row, 8'h00);
                                phase_next = PH_WAIT;
                            end
                            OP_ID:
                            begin
                                job        = mk_seq(J_ID, '0, 8'h00);
                                same_next  = 1'b1;
                                first_next = '0;
                                phase_next = PH_ID;
                            end
                            default:
                            begin
                                job        = mk_seq(J_RESET, '0, 8'h00);
                                phase_next = PH_WAIT;
                            end
                        endcase
                    end
                end
                OP_HOST:
                begin
                    job_push = 1'b1;
                    if (phase_reg != PH_PROG)
                    begin
                        job = mk_single(K_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ST_UNEXP);
                    end
                    else if (count_inc >= CNT_W'(PAGE_BYTES))
                    begin
                        job        = mk_seq(J_WRLAST, '0, host_byte);
                        count_next = '0;
                        wait_next  = '0;
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        job        = mk_single(K_WR, host_byte, 1'b0, 8'h00, 1'b0, ST_OK);
                        count_next = count_inc;
                    end
                end
                OP_BUS:
                begin
                    job_push = 1'b1;
                    priority if (phase_reg == PH_READ)
                    begin
                        if (count_inc >= CNT_W'(PAGE_BYTES))
                        begin
                            job = mk_single(K_NONE, 8'h00, 1'b1, bus_byte, 1'b1, ST_OK);
                            count_next = '0;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            job = mk_single(K_RD, 8'h00, 1'b1, bus_byte, 1'b0, ST_OK);
                            count_next = count_inc;
                        end
                    end
                    else if (phase_reg == PH_ID)
                    begin
                        if (count_reg == '0)
                        begin
                            first_next = bus_byte;
                        end
                        same_next  = same_now;
                        count_next = count_inc;
                        if (count_inc >= CNT_W'(ID_BYTES))
                        begin
                            job = mk_single(K_NONE, 8'h00, 1'b1, bus_byte, 1'b1,
                                            same_now ? ST_ID_SAME : ST_OK);
                            count_next = '0;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            job = mk_single(K_RD, 8'h00, 1'b1, bus_byte, 1'b0, ST_OK);
                        end
                    end
                    else if (phase_reg == PH_STAT)
                    begin
                        job = mk_single(K_NONE, 8'h00, 1'b0, 8'h00, 1'b1,
                                        bus_byte[0] ? ST_FAIL : ST_OK);
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        job = mk_single(K_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ST_UNEXP);
                    end
                end
                OP_TICK:
                begin
                    // Ticks outside the wait phase are dropped without a result.
                    if (phase_reg == PH_WAIT)
                    begin
                        if (ready_req)
                        begin
                            job_push = 1'b1;
                            priority if (kind_reg == OP_READ)
                            begin
                                job = mk_single(K_RD, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
                                count_next = '0;
                                phase_next = PH_READ;
                            end
                            else if (kind_reg == OP_PROG || kind_reg == OP_ERASE)
                            begin
                                job        = mk_seq(J_STATUS, '0, 8'h00);
                                phase_next = PH_STAT;
                            end
                            else
                            begin
                                job = mk_single(K_NONE, 8'h00, 1'b0, 8'h00, 1'b1, ST_OK);
                                phase_next = PH_IDLE;
                            end
                        end
                        else
                        begin
                            wait_next = wait_inc;
                            if (wait_inc >= timeout_ticks)
                            begin
                                job_push = 1'b1;
                                job = mk_single(K_NONE, 8'h00, 1'b0, 8'h00, 1'b1,
                                                ST_TIMEOUT);
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= '0;
            count_reg <= '0;
            wait_reg  <= '0;
            first_reg <= '0;
            same_reg  <= 1'b1;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            count_reg <= count_next;
            wait_reg  <= wait_next;
            first_reg <= first_next;
            same_reg  <= same_next;
        end
    end

endmodule

/* hdl/nfcs_job_fifo.sv */
// Short job queue between the front and the back.
module nfcs_job_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  nfcs_pkg::job_t wdata,
    output logic           full,
    input  logic           pop,
    output nfcs_pkg::job_t rdata,
    output logic           valid
);
    import nfcs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/nfcs_back.sv */
// Back part: expands each job into its bus cycle words, one per clock while the output register is free or popped.
module nfcs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  nfcs_pkg::job_t job,
    output logic           job_pop,
    input  logic           pop,
    output logic           empty,
    output nfcs_pkg::res_t res
);
    import nfcs_pkg::*;

    logic [2:0] idx_reg, idx_next;
    res_t       out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    logic       load;
    logic       is_last;
    res_t       word;

    function automatic logic [2:0] last_idx(logic [2:0] jtype);
        logic [2:0] n;
        unique case (jtype)
            J_READ:   n = 3'd6;
            J_PROG:   n = 3'd5;
            J_ERASE:  n = 3'd4;
            J_ID:     n = 3'd2;
            J_WRLAST: n = 3'd1;
            J_STATUS: n = 3'd1;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] row_byte(logic [ROW_W-1:0] row, logic [1:0] sel);
        logic [7:0] b;
        unique case (sel)
            2'd0:    b = row[7:0];
            2'd1:    b = row[15:8];
            default: b = row[23:16];
        endcase
        return b;
    endfunction

    function automatic res_t cyc(logic [2:0] kind, logic [7:0] bus);
        res_t r;
        r      = '0;
        r.kind = kind;
        r.bus  = bus;
        return r;
    endfunction

    always_comb
    begin
        word = '0;
        unique case (job.jtype)
            J_READ, J_PROG:
            begin
                unique case (idx_reg)
                    3'd0:       word = cyc(K_CMD, (job.jtype == J_READ) ? CMD_READ0 : CMD_PROG0);
                    3'd1, 3'd2: word = cyc(K_ADDR, COL_ADDR);
                    3'd3:       word = cyc(K_ADDR, row_byte(job.row, 2'd0));
                    3'd4:       word = cyc(K_ADDR, row_byte(job.row, 2'd1));
                    3'd5:       word = cyc(K_ADDR, row_byte(job.row, 2'd2));
                    default:    word = cyc(K_CMD, CMD_READ1);
                endcase
            end
            J_ERASE:
            begin
                unique case (idx_reg)
                    3'd0:    word = cyc(K_CMD, CMD_ERASE0);
                    3'd1:    word = cyc(K_ADDR, row_byte(job.row, 2'd0));
                    3'd2:    word = cyc(K_ADDR, row_byte(job.row, 2'd1));
                    3'd3:    word = cyc(K_ADDR, row_byte(job.row, 2'd2));
                    default: word = cyc(K_CMD, CMD_ERASE1);
                endcase
            end
            J_ID:
            begin
                unique case (idx_reg)
                    3'd0:    word = cyc(K_CMD, CMD_READID);
                    3'd1:    word = cyc(K_ADDR, ID_ADDR);
                    default: word = cyc(K_RD, 8'h00);
                endcase
            end
            J_RESET:
            begin
                word = cyc(K_CMD, CMD_RESET);
            end
            J_WRLAST:
            begin
                word = (idx_reg == 3'd0) ? cyc(K_WR, job.bus) : cyc(K_CMD, CMD_PROG1);
            end
            J_STATUS:
            begin
                word = (idx_reg == 3'd0) ? cyc(K_CMD, CMD_STATUS) : cyc(K_RD, 8'h00);
            end
            default:
            begin
                word.kind = job.kind;
                word.bus  = job.bus;
                word.hv   = job.hv;
                word.hd   = job.hd;
                word.done = job.done;
                word.st   = job.st;
            end
        endcase
        word.last = is_last;
    end

    // The output register refills in the same cycle that its word is popped, if a job is waiting.
    assign load    = job_valid & (~out_valid_reg | pop);
    assign is_last = (idx_reg == last_idx(job.jtype));
    assign job_pop = load & is_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_next       = word;
            out_valid_next = 1'b1;
            idx_next       = is_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign empty = ~out_valid_reg;
    assign res   = out_reg;

endmodule

/* hdl/nand_flash_command_sequencer_core.sv */
// Top level of the NAND flash command sequencer: configuration port and the front, queue and back.
// An accepted item's job goes into the job queue, then is expanded into the output register on the
// result ports. The front takes a new item while the job queue is not full; a request emits one
// word per cycle when popped, up to seven (read page), so the back end sets the sustained rate.
// The job queue holds JOB_DEPTH jobs; full rises only when it is out of room.
// Reset (rst_n low, asynchronous) returns to idle, empties all queues and loads the timeout.
module nand_flash_command_sequencer_core #(
    parameter int PAGE_BYTES      = 2112,
    parameter int PAGES_PER_BLOCK = 64,
    parameter int JOB_DEPTH       = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic [2:0]                   op,
    input  logic [nfcs_pkg::ROW_W-1:0]   page_number,
    input  logic [nfcs_pkg::BLOCK_W-1:0] block_number,
    input  logic [7:0]                   host_byte,
    input  logic [7:0]                   bus_byte,
    input  logic                         ready_req,
    output logic                         empty,
    input  logic                         pop,
    output logic [2:0]                   cycle_kind,
    output logic [7:0]                   bus_value,
    output logic                         host_data_valid,
    output logic [7:0]                   host_data,
    output logic                         done_res,
    output logic [2:0]                   status,
    output logic                         last
);
    import nfcs_pkg::*;

    localparam logic [1:0] ADDR_TIMEOUT = 2'd0;

    logic [31:0] timeout_reg;
    logic        job_push;
    job_t        job_in;
    job_t        job_head;
    logic        job_full;
    logic        job_valid;
    logic        job_pop;
    res_t        res;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TIMEOUT) ? timeout_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_TIMEOUT)
        begin
            timeout_reg <= pwdata;
        end
    end

    nfcs_front #(
        .PAGE_BYTES      (PAGE_BYTES),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .op            (op),
        .page_number   (page_number),
        .block_number  (block_number),
        .host_byte     (host_byte),
        .bus_byte      (bus_byte),
        .ready_req     (ready_req),
        .timeout_ticks (timeout_reg),
        .job_full      (job_full),
        .job_push      (job_push),
        .job           (job_in)
    );

    nfcs_job_fifo #(
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_head),
        .valid (job_valid)
    );

    nfcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign full            = job_full;
    assign cycle_kind      = res.kind;
    assign bus_value       = res.bus;
    assign host_data_valid = res.hv;
    assign host_data       = res.hd;
    assign done_res        = res.done;
    assign status          = res.st;
    assign last            = res.last;

endmodule

/* hdl/nfcs_checker.sv */
// Port checker for the NAND flash command sequencer, bound to the top level.
module nfcs_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [2:0] cycle_kind,
    input logic [7:0] bus_value,
    input logic       host_data_valid,
    input logic [7:0] host_data,
    input logic       done_res,
    input logic [2:0] status,
    input logic       last
);
    import nfcs_pkg::*;

    // A waiting word that is not popped keeps its kind, bus value, status and last flag.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(cycle_kind) && $stable(bus_value)
                              && $stable(status) && $stable(last)))
        else $error("waiting result word changed before it was popped");

    // A finishing word carries no bus cycle and closes its item.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && done_res) |-> (last && cycle_kind == K_NONE))
        else $error("done word is not the last word or drives a bus cycle");

    // A nonzero status is either a final report or a rejection word.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_OK) |->
            (done_res || (status == ST_UNEXP && cycle_kind == K_NONE && last)))
        else $error("status set on a word that neither finishes nor rejects");

    // Host data is zero unless it is flagged valid.
    a_host_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !host_data_valid) |-> (host_data == 8'h00))
        else $error("host data nonzero without its valid flag");

endmodule

bind nand_flash_command_sequencer_core nfcs_port_checker u_nfcs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (empty),
    .pop             (pop),
    .cycle_kind      (cycle_kind),
    .bus_value       (bus_value),
    .host_data_valid (host_data_valid),
    .host_data       (host_data),
    .done_res        (done_res),
    .status          (status),
    .last            (last)
);

/* tb/nfcs_checker.sv */
// Checker for the NAND flash command sequencer: predicts every result word and compares it.
module nfcs_checker #(
    parameter int         PAGE_BYTES      = 2112,
    parameter int         PAGES_PER_BLOCK = 64,
    parameter logic [1:0] TIMEOUT_ADDR    = 2'd0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,
    input  logic                         push,
    input  logic                         full,
    input  logic [2:0]                   op,
    input  logic [nfcs_pkg::ROW_W-1:0]   page_number,
    input  logic [nfcs_pkg::BLOCK_W-1:0] block_number,
    input  logic [7:0]                   host_byte,
    input  logic [7:0]                   bus_byte,
    input  logic                         ready_req,
    input  logic                         empty,
    input  logic                         pop,
    input  logic [2:0]                   cycle_kind,
    input  logic [7:0]                   bus_value,
    input  logic                         host_data_valid,
    input  logic [7:0]                   host_data,
    input  logic                         done_res,
    input  logic [2:0]                   status,
    input  logic                         last,
    output int                           pending,
    output int                           errors
);
    import nfcs_pkg::*;

    localparam logic [31:0] TIMEOUT_AT_RESET = 32'd3_000_000;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_WAIT,
        SQ_PAGE_IN,
        SQ_PAGE_OUT,
        SQ_STATUS,
        SQ_ID
    } seq_phase_e;

    seq_phase_e  phase_m;
    logic [2:0]  req_m;
    logic [11:0] count_m;
    logic [31:0] wait_m;
    logic [7:0]  id_first_m;
    logic        id_same_m;
    logic [31:0] timeout_m;
    res_t        words_q[$];
    int          fail_count = 0;

    assign errors = fail_count;

    task automatic report(input string what);
        fail_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic put_word(input logic [2:0] kind, input logic [7:0] bus, input logic hv,
                            input logic [7:0] hd, input logic done, input logic [2:0] st);
        res_t w;
        w.kind = kind;
        w.bus  = bus;
        w.hv   = hv;
        w.hd   = hd;
        w.done = done;
        w.st   = st;
        w.last = 1'b0;
        words_q.push_back(w);
    endtask

    // Row address goes out low byte first.
    task automatic put_row(input logic [23:0] row);
        put_word(K_ADDR, row[7:0], 1'b0, 8'h00, 1'b0, ST_OK);
        put_word(K_ADDR, row[15:8], 1'b0, 8'h00, 1'b0, ST_OK);
        put_word(K_ADDR, row[23:16], 1'b0, 8'h00, 1'b0, ST_OK);
    endtask

    task automatic predict_item(input logic [2:0] o, input logic [23:0] pg,
                                input logic [17:0] blk, input logic [7:0] hb,
                                input logic [7:0] bb, input logic rdy);
        int          start_size;
        int          nxt;
        logic [23:0] row;
        start_size = words_q.size();
        if (o <= OP_RESET) begin
            if (phase_m != SQ_IDLE) begin
                put_word(K_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ST_UNEXP);
            end else begin
                req_m   = o;
                wait_m  = '0;
                count_m = '0;
                case (o)
                    OP_READ: begin
                        put_word(K_CMD, CMD_READ0, 1'b0, 8'h00, 1'b0, ST_OK);
                        put_word(K_ADDR, COL_ADDR, 1'b0, 8'h00, 1'b0, ST_OK);
                        put_word(K_ADDR, COL_ADDR, 1'b0, 8'h00, 1'b0, ST_OK);
                        put_row(pg);
                        put_word(K_CMD, CMD_READ1, 1'b0, 8'h00, 1'b0, ST_OK);
                        phase_m = SQ_WAIT;
                    end
                    OP_PROG: begin
                        put_word(K_CMD, CMD_PROG0, 1'b0, 8'h00, 1'b0, ST_OK);
                        put_word(K_ADDR, COL_ADDR, 1'b0, 8'h00, 1'b0, ST_OK);
                        put_word(K_ADDR, COL_ADDR, 1'b0, 8'h00, 1'b0, ST_OK);
                        put_row(pg);
                        phase_m = SQ_PAGE_OUT;
                    end
                    OP_ERASE: begin
                        row = 24'(32'(blk) * 32'(PAGES_PER_BLOCK));
                        put_word(K_CMD, CMD_ERASE0, 1'b0, 8'h00, 1'b0, ST_OK);
                        put_row(row);
                        put_word(K_CMD, CMD_ERASE1, 1'b0, 8'h00, 1'b0, ST_OK);
                        phase_m = SQ_WAIT;
                    end
                    OP_ID: begin
                        put_word(K_CMD, CMD_READID, 1'b0, 8'h00, 1'b0, ST_OK);
                        put_word(K_ADDR, ID_ADDR, 1'b0, 8'h00, 1'b0, ST_OK);
                        put_word(K_RD, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
                        id_same_m  = 1'b1;
                        id_first_m = '0;
                        phase_m    = SQ_ID;
                    end
                    default: begin
                        put_word(K_CMD, CMD_RESET, 1'b0, 8'h00, 1'b0, ST_OK);
                        phase_m = SQ_WAIT;
                    end
                endcase
            end
        end else if (o == OP_HOST) begin
            if (phase_m != SQ_PAGE_OUT) begin
                put_word(K_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ST_UNEXP);
            end else begin
                nxt = int'(count_m) + 1;
                put_word(K_WR, hb, 1'b0, 8'h00, 1'b0, ST_OK);
                if (nxt >= PAGE_BYTES) begin
                    put_word(K_CMD, CMD_PROG1, 1'b0, 8'h00, 1'b0, ST_OK);
                    count_m = '0;
                    wait_m  = '0;
                    phase_m = SQ_WAIT;
                end else begin
                    count_m = 12'(nxt);
                end
            end
        end else if (o == OP_BUS) begin
            case (phase_m)
                SQ_PAGE_IN: begin
                    // Each page byte rides on the next strobe; the final one closes the request.
                    nxt = int'(count_m) + 1;
                    if (nxt >= PAGE_BYTES) begin
                        put_word(K_NONE, 8'h00, 1'b1, bb, 1'b1, ST_OK);
                        count_m = '0;
                        phase_m = SQ_IDLE;
                    end else begin
                        put_word(K_RD, 8'h00, 1'b1, bb, 1'b0, ST_OK);
                        count_m = 12'(nxt);
                    end
                end
                SQ_ID: begin
                    if (count_m == '0)
                        id_first_m = bb;
                    else if (bb != id_first_m)
                        id_same_m = 1'b0;
                    count_m = count_m + 12'd1;
                    if (count_m >= 12'(ID_BYTES)) begin
                        put_word(K_NONE, 8'h00, 1'b1, bb, 1'b1, id_same_m ? ST_ID_SAME : ST_OK);
                        count_m = '0;
                        phase_m = SQ_IDLE;
                    end else begin
                        put_word(K_RD, 8'h00, 1'b1, bb, 1'b0, ST_OK);
                    end
                end
                SQ_STATUS: begin
                    put_word(K_NONE, 8'h00, 1'b0, 8'h00, 1'b1, bb[0] ? ST_FAIL : ST_OK);
                    phase_m = SQ_IDLE;
                end
                default: put_word(K_NONE, 8'h00, 1'b0, 8'h00, 1'b0, ST_UNEXP);
            endcase
        end else if (phase_m == SQ_WAIT) begin
            if (rdy) begin
                if (req_m == OP_READ) begin
                    put_word(K_RD, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
                    count_m = '0;
                    phase_m = SQ_PAGE_IN;
                end else if (req_m == OP_PROG || req_m == OP_ERASE) begin
                    put_word(K_CMD, CMD_STATUS, 1'b0, 8'h00, 1'b0, ST_OK);
                    put_word(K_RD, 8'h00, 1'b0, 8'h00, 1'b0, ST_OK);
                    phase_m = SQ_STATUS;
                end else begin
                    put_word(K_NONE, 8'h00, 1'b0, 8'h00, 1'b1, ST_OK);
                    phase_m = SQ_IDLE;
                end
            end else begin
                // The tick counter sticks at its top value, and a zero limit fires on the first tick.
                if (wait_m != '1)
                    wait_m = wait_m + 32'd1;
                if (wait_m >= timeout_m) begin
                    put_word(K_NONE, 8'h00, 1'b0, 8'h00, 1'b1, ST_TIMEOUT);
                    phase_m = SQ_IDLE;
                end
            end
        end
        if (words_q.size() > start_size)
            words_q[words_q.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_t seen;
        res_t want;
        if (!rst_n) begin
            phase_m    = SQ_IDLE;
            req_m      = '0;
            count_m    = '0;
            wait_m     = '0;
            id_first_m = '0;
            id_same_m  = 1'b1;
            timeout_m  = TIMEOUT_AT_RESET;
            words_q.delete();
            pending <= 0;
        end else begin
            if (pop && !empty) begin
                seen = {cycle_kind, bus_value, host_data_valid, host_data, done_res, status,
                        last};
                if (words_q.size() == 0) begin
                    report($sformatf("word with nothing expected: kind %0h status %0h",
                                     cycle_kind, status));
                end else begin
                    want = words_q.pop_front();
                    check_field("cycle_kind", 32'(seen.kind), 32'(want.kind));
                    check_field("bus_value", 32'(seen.bus), 32'(want.bus));
                    check_field("host_data_valid", 32'(seen.hv), 32'(want.hv));
                    check_field("host_data", 32'(seen.hd), 32'(want.hd));
                    check_field("done_res", 32'(seen.done), 32'(want.done));
                    check_field("status", 32'(seen.st), 32'(want.st));
                    check_field("last", 32'(seen.last), 32'(want.last));
                end
            end
            if (psel && penable && pready && paddr == TIMEOUT_ADDR) begin
                if (pwrite)
                    timeout_m = pwdata;
                else
                    check_field("timeout register", prdata, timeout_m);
            end
            if (push && !full)
                predict_item(op, page_number, block_number, host_byte, bus_byte, ready_req);
            pending <= words_q.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// Top of the sequencer testbench: clock, reset, request and data stimulus, and the verdict.
module tb_top;
    import nfcs_pkg::*;

    // A full page is far longer than the run, so page transfers are only ever started.
    localparam int          PAGE_BYTES      = 2112;
    localparam int          PAGES_PER_BLOCK = 64;
    localparam logic [1:0]  REG_TIMEOUT     = 2'd0;
    localparam int          SETTLE          = 8;
    localparam int          LONG_HOLD       = 300;
    localparam int          LIMIT_CYCLES    = 400_000;
    localparam int          PROG_BYTES      = 20;

    // Ops that may be thrown in as noise in each phase, one bit per op code.
    localparam logic [7:0] NOISE_IDLE = 8'b1110_0000;
    localparam logic [7:0] NOISE_WAIT = 8'b0111_1111;
    localparam logic [7:0] NOISE_BUS  = 8'b1011_1111;
    localparam logic [7:0] NOISE_HOST = 8'b1101_1111;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_HALF,
        POP_RARE
    } pop_mode_e;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [1:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 push;
    logic                 full;
    logic [2:0]           op;
    logic [ROW_W-1:0]     page_number;
    logic [BLOCK_W-1:0]   block_number;
    logic [7:0]           host_byte;
    logic [7:0]           bus_byte;
    logic                 ready_req;
    logic                 empty;
    logic                 pop;
    logic [2:0]           cycle_kind;
    logic [7:0]           bus_value;
    logic                 host_data_valid;
    logic [7:0]           host_data;
    logic                 done_res;
    logic [2:0]           status;
    logic                 last;
    int                   pending;
    int                   errors;

    logic [31:0] cur_timeout = 32'd3_000_000;
    int          burst_left  = 0;
    bit          hold_req    = 1'b0;

    always #10 clk = ~clk;

    nand_flash_command_sequencer_core #(
        .PAGE_BYTES     (PAGE_BYTES),
        .PAGES_PER_BLOCK(PAGES_PER_BLOCK)
    ) DUT (.*);

    nfcs_checker #(
        .PAGE_BYTES     (PAGE_BYTES),
        .PAGES_PER_BLOCK(PAGES_PER_BLOCK),
        .TIMEOUT_ADDR   (REG_TIMEOUT)
    ) u_checker (.*);

    // Offers one word and holds it until the core takes it; bursts are split by random gaps.
    task automatic offer(input logic [2:0] o, input logic [23:0] pg, input logic [17:0] blk,
                         input logic [7:0] hb, input logic [7:0] bb, input logic rdy);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        push         <= 1'b1;
        op           <= o;
        page_number  <= pg;
        block_number <= blk;
        host_byte    <= hb;
        bus_byte     <= bb;
        ready_req    <= rdy;
        do @(posedge clk); while (full);
        burst_left--;
    endtask

    task automatic offer_rand(input logic [2:0] o);
        offer(o, 24'($urandom), 18'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic noise(input logic [7:0] allowed);
        logic [2:0] o;
        do o = 3'($urandom_range(0, 7)); while (!allowed[o]);
        offer_rand(o);
    endtask

    task automatic maybe_noise(input logic [7:0] allowed);
        if ($urandom_range(0, 15) == 0)
            noise(allowed);
    endtask

    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb(input logic wr, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_TIMEOUT;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_timeout(input logic [31:0] value);
        drain();
        apb(1'b1, value);
        apb(1'b0, '0);
        cur_timeout = value;
    endtask

    // Either runs the wait into its timeout or ends it with a ready tick before the limit.
    task automatic await_ready(input bit may_finish, output bit reached);
        int n;
        if (!may_finish || (cur_timeout <= 8 && $urandom_range(0, 3) == 0)) begin
            n = (cur_timeout == 0) ? 1 : int'(cur_timeout);
            repeat (n) begin
                maybe_noise(NOISE_WAIT);
                offer(OP_TICK, 24'($urandom), 18'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            end
            reached = 1'b0;
        end else begin
            n = $urandom_range(0, 3);
            if (cur_timeout <= 32'(n))
                n = (cur_timeout == 0) ? 0 : int'(cur_timeout) - 1;
            repeat (n) begin
                maybe_noise(NOISE_WAIT);
                offer(OP_TICK, 24'($urandom), 18'($urandom), 8'($urandom), 8'($urandom), 1'b0);
            end
            maybe_noise(NOISE_WAIT);
            offer(OP_TICK, 24'($urandom), 18'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            reached = 1'b1;
        end
    endtask

    // A page read is always run into its ready timeout, which needs a short limit.
    task automatic read_page();
        bit reached;
        offer_rand(OP_READ);
        await_ready(1'b0, reached);
    endtask

    // Starts a page program and sends only its first bytes, so the core stays mid-page.
    task automatic program_start(input int count);
        offer_rand(OP_PROG);
        repeat (count) begin
            maybe_noise(NOISE_HOST);
            offer_rand(OP_HOST);
        end
    endtask

    task automatic erase_block();
        bit reached;
        offer_rand(OP_ERASE);
        await_ready(1'b1, reached);
        if (reached) begin
            maybe_noise(NOISE_BUS);
            offer_rand(OP_BUS);
        end
    endtask

    task automatic read_id();
        logic [7:0] id_byte;
        bit         same;
        same    = 1'($urandom_range(0, 1));
        id_byte = 8'($urandom);
        offer_rand(OP_ID);
        repeat (ID_BYTES) begin
            maybe_noise(NOISE_BUS);
            offer(OP_BUS, 24'($urandom), 18'($urandom), 8'($urandom),
                  same ? id_byte : 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_random(input int count);
        int  pick;
        bit  reached;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                if (cur_timeout <= 8)
                    read_page();
                else
                    read_id();
            end else if (pick < 45) begin
                erase_block();
            end else if (pick < 65) begin
                read_id();
            end else if (pick < 80) begin
                offer_rand(OP_RESET);
                await_ready(1'b1, reached);
            end else if (pick < 92) begin
                repeat ($urandom_range(1, 3)) noise(NOISE_IDLE);
            end else begin
                drain();
            end
        end
    endtask

    // Result side: stalls on a pattern of its own, and once holds off long enough to fill the core.
    initial begin
        pop_mode_e mode;
        int        mode_left;
        mode_left = 0;
        mode      = POP_ALWAYS;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = pop_mode_e'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    POP_ALWAYS: pop <= 1'b1;
                    POP_HALF:   pop <= 1'($urandom_range(0, 1));
                    default:    pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        #(20 * LIMIT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= REG_TIMEOUT;
        pwdata       <= '0;
        push         <= 1'b0;
        op           <= OP_TICK;
        page_number  <= '0;
        block_number <= '0;
        host_byte    <= '0;
        bus_byte     <= '0;
        ready_req    <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The timeout register must come up with its reset value.
        apb(1'b0, '0);
        set_timeout(32'd3);

        offer(OP_RESET, '0, '0, '0, '0, 1'b0);
        offer(OP_TICK, '1, '1, '1, '1, 1'b1);
        offer(OP_ERASE, '0, '1, '0, '0, 1'b0);
        offer(OP_TICK, '0, '0, '0, '0, 1'b0);
        offer(OP_TICK, '0, '0, '0, '0, 1'b1);
        offer(OP_BUS, '0, '0, '0, 8'h01, 1'b0);
        offer(OP_ID, '0, '0, '0, '0, 1'b0);
        for (int i = 0; i < ID_BYTES; i++)
            offer(OP_BUS, '0, '0, '0, 8'hA5, 1'b0);
        offer(OP_ID, '1, '1, '1, '1, 1'b1);
        for (int i = 0; i < ID_BYTES; i++)
            offer(OP_BUS, '0, '0, '0, (i == ID_BYTES - 1) ? 8'hFF : 8'h00, 1'b0);
        offer(OP_READ, '1, '0, '0, '0, 1'b0);
        repeat (3) offer(OP_TICK, '0, '0, '0, '0, 1'b0);
        // Idle core: a tick is dropped, data words are turned away.
        offer(OP_TICK, '0, '0, '0, '0, 1'b1);
        offer(OP_HOST, '0, '0, 8'hFF, '0, 1'b0);
        offer(OP_BUS, '0, '0, '0, 8'hFF, 1'b0);
        // Requests that arrive while a reset is still waiting are turned away.
        offer(OP_RESET, '0, '0, '0, '0, 1'b0);
        offer(OP_READ, '0, '0, '0, '0, 1'b0);
        offer(OP_PROG, '0, '0, '0, '0, 1'b0);
        offer(OP_TICK, '0, '0, '0, '0, 1'b1);

        set_timeout(32'd5);
        run_random(6);
        set_timeout(32'd0);
        run_random(4);
        set_timeout(32'd1);
        run_random(4);
        set_timeout(32'hFFFF_FFFF);
        run_random(3);
        set_timeout(32'd5);
        run_random(3);
        drain();

        // The result side holds off while a page program streams in, so the core fills up.
        hold_req = 1'b1;
        program_start(PROG_BYTES);
        drain();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
